FILE: src/tmt_pkg.sv
// Shared constants and types for the trace mute and taper unit.
package tmt_pkg;

	// Defaults for the top-level parameters
	localparam int MAX_SAMPLES_DEF = 4096;
	localparam int SAMPLE_BITS_DEF = 24;
	localparam int WEIGHT_BITS_DEF = 16;

	// Fixed field widths
	localparam int IDX_W     = 12;
	localparam int LEN_W     = 13;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int IND_W     = 24;

	// Taper divider: quotient bits and dividend width for the cosine argument
	localparam int DIV_BITS      = 25;
	localparam int NUM_SHIFT_COS = 24;
	localparam int DVD_W         = LEN_W + DIV_BITS;

	// Cosine polynomial pipeline
	localparam int HORNER_N      = 5;
	localparam int HORNER_STAGES = HORNER_N * 5 + 1;
	localparam int COS_LAT       = HORNER_STAGES + 2;

	// Start accepted to result strobe, in cycles
	localparam int PIPE_LAT = 6 + DIV_BITS + COS_LAT;

	localparam int Q30_W = 31;
	localparam logic [Q30_W-1:0] Q30_ONE = 31'h4000_0000;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	// Horner divisors of the 1 - cos series, innermost first
	localparam logic [7:0] HORNER_DIV [HORNER_N] = '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12};

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRONT_MODE,
		CFG_COSINE_TAPER,
		CFG_BACKWARD_COMPAT,
		CFG_WINDOW_START,
		CFG_WINDOW_END,
		CFG_TRACE_SAMPLES,
		CFG_INDICATE_WIDTH,
		CFG_INDICATE_VALUE
	} cfg_reg_t;

endpackage

FILE: src/tmt_cos.sv
// Pipelined raised-cosine evaluation: half of 1 - cos(pi*y) in Q30.
module tmt_cos (
	input  logic                     clk,
	input  logic [23:0]              y,
	output logic [tmt_pkg::Q30_W-1:0] half
);
	import tmt_pkg::*;

	// Eight quotient bits of a division by a small constant
	function automatic logic [15:0] div8_step(logic [7:0] rem, logic [7:0] din,
		logic [7:0] dvsr);
		logic [8:0] r;
		logic [7:0] rr;
		logic [7:0] q;
		rr = rem;
		q  = '0;
		for (int b = 7; b >= 0; b--) begin
			r = {rr, din[b]};
			if (r >= {1'b0, dvsr}) begin
				r    = r - {1'b0, dvsr};
				q[b] = 1'b1;
			end
			rr = r[7:0];
		end
		return {rr, q};
	endfunction

	logic [30:0] ang_s0;
	logic [31:0] a2_s   [0:HORNER_STAGES];
	logic [31:0] prod_s [0:HORNER_STAGES];
	logic [7:0]  rem_s  [0:HORNER_STAGES];
	logic [31:0] quo_s  [0:HORNER_STAGES];
	logic [Q30_W-1:0] p_fin;

	// Scale the argument by pi, then square it
	always_ff @(posedge clk) begin
		ang_s0    <= 31'((56'(y) * 56'(PI_Q30)) >> 24);
		a2_s[0]   <= 32'((62'(ang_s0) * 62'(ang_s0)) >> 30);
	end

	// Each round: one multiply stage, then four byte stages of constant division
	for (genvar r = 0; r < HORNER_N; r++) begin : g_round
		localparam int K = 1 + 5 * r;
		logic [Q30_W-1:0] p_in;

		if (r == 0) begin : g_first
			assign p_in = Q30_ONE;
		end else begin : g_next
			assign p_in = Q30_ONE - Q30_W'(quo_s[K-1]);
		end

		always_ff @(posedge clk) begin
			a2_s[K]   <= a2_s[K-1];
			prod_s[K] <= 32'((63'(a2_s[K-1]) * 63'(p_in)) >> 30);
			rem_s[K]  <= '0;
			quo_s[K]  <= '0;
		end

		for (genvar d = 0; d < 4; d++) begin : g_byte
			logic [15:0] st;
			assign st = div8_step(rem_s[K+d], prod_s[K+d][31:24], HORNER_DIV[r]);
			always_ff @(posedge clk) begin
				a2_s[K+d+1]   <= a2_s[K+d];
				prod_s[K+d+1] <= prod_s[K+d] << 8;
				rem_s[K+d+1]  <= st[15:8];
				quo_s[K+d+1]  <= {quo_s[K+d][23:0], st[7:0]};
			end
		end
	end

	// Last multiply gives twice 1 - cos; halve twice for the raised-cosine half
	assign p_fin = Q30_ONE - Q30_W'(quo_s[HORNER_STAGES-1]);

	always_ff @(posedge clk) begin
		prod_s[HORNER_STAGES] <= 32'((63'(a2_s[HORNER_STAGES-1]) * 63'(p_fin)) >> 30);
	end

	assign half = Q30_W'(prod_s[HORNER_STAGES] >> 2);

endmodule

FILE: src/trace_mute_taper_unit.sv
// Top level of the trace mute and taper unit.
//
//   channel   signals                                          direction
//   input     start, busy (out), sample_in, sample_index,
//             mute_point, taper_samples                        in
//   result    done, sample_out, boundary_sample,
//             whole_trace_muted                                out
//   config    cfg_wr_en, cfg_index, cfg_wdata                  in
//
// One word enters every cycle. The pipeline is made up of the 25-stage taper
// divider and the 28-stage cosine polynomial pipeline, plus decode, weight,
// multiply and output stages.
// Reset clears the valid bits and loads the register defaults; busy is high
// during reset only. The receiver takes every result in its strobe cycle.
module trace_mute_taper_unit #(
	parameter int MAX_SAMPLES = tmt_pkg::MAX_SAMPLES_DEF,
	parameter int SAMPLE_BITS = tmt_pkg::SAMPLE_BITS_DEF,
	parameter int WEIGHT_BITS = tmt_pkg::WEIGHT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [SAMPLE_BITS-1:0] sample_in,
	input  logic [tmt_pkg::IDX_W-1:0]     sample_index,
	input  logic [tmt_pkg::LEN_W-1:0]     mute_point,
	input  logic [tmt_pkg::LEN_W-1:0]     taper_samples,
	input  logic                          cfg_wr_en,
	input  logic [tmt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tmt_pkg::CFG_W-1:0]     cfg_wdata,
	output logic                          done,
	output logic signed [SAMPLE_BITS-1:0] sample_out,
	output logic [tmt_pkg::LEN_W-1:0]     boundary_sample,
	output logic                          whole_trace_muted
);
	import tmt_pkg::*;

	typedef logic signed [15:0] pos_t;
	typedef enum logic [1:0] {ACT_PASS, ACT_ZERO, ACT_INDICATE, ACT_TAPER} act_t;
	typedef struct packed {
		act_t                   act;
		logic [SAMPLE_BITS-1:0] sample;
		logic [LEN_W-1:0]       bound;
		logic                   whole;
	} side_t;

	localparam int SIDE_LAT = DIV_BITS + COS_LAT;
	localparam int PW       = SAMPLE_BITS + WEIGHT_BITS + 1;
	localparam logic [WEIGHT_BITS-1:0] W_ONE = {1'b1, {(WEIGHT_BITS-1){1'b0}}};
	localparam logic signed [PW-1:0] S_MAX = {{(WEIGHT_BITS+2){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [PW-1:0] S_MIN = {{(WEIGHT_BITS+2){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};

	function automatic pos_t pmax(pos_t a, pos_t b);
		return (a > b) ? a : b;
	endfunction

	function automatic pos_t pmin(pos_t a, pos_t b);
		return (a < b) ? a : b;
	endfunction

	// Configuration registers
	logic                    front_mode_q, cosine_taper_q, backward_compat_q;
	logic [IDX_W-1:0]        window_start_q, window_end_q;
	logic [LEN_W-1:0]        trace_samples_q, indicate_width_q;
	logic signed [IND_W-1:0] indicate_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_mode_q      <= 1'b1;
			cosine_taper_q    <= 1'b1;
			backward_compat_q <= 1'b0;
			window_start_q    <= '0;
			window_end_q      <= '1;
			trace_samples_q   <= LEN_W'(4096);
			indicate_width_q  <= '0;
			indicate_value_q  <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_FRONT_MODE:      front_mode_q      <= cfg_wdata[0];
				CFG_COSINE_TAPER:    cosine_taper_q    <= cfg_wdata[0];
				CFG_BACKWARD_COMPAT: backward_compat_q <= cfg_wdata[0];
				CFG_WINDOW_START:    window_start_q    <= cfg_wdata[IDX_W-1:0];
				CFG_WINDOW_END:      window_end_q      <= cfg_wdata[IDX_W-1:0];
				CFG_TRACE_SAMPLES:   trace_samples_q   <= cfg_wdata[LEN_W-1:0];
				CFG_INDICATE_WIDTH:  indicate_width_q  <= cfg_wdata[LEN_W-1:0];
				CFG_INDICATE_VALUE:  indicate_value_q  <= cfg_wdata[IND_W-1:0];
			endcase
		end
	end

	assign busy = ~arst_n;

	// Stage 1: capture the input word
	logic                   v_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [LEN_W-1:0]       mute_s1, taper_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
		end
	end

	always_ff @(posedge clk) begin
		sample_s1 <= sample_in;
		idx_s1    <= sample_index;
		mute_s1   <= mute_point;
		taper_s1  <= taper_samples;
	end

	// Stage 2: clamp trace length and mute point
	pos_t                   n_c, m_c, n_s2, m_s2;
	logic                   v_s2;
	logic [SAMPLE_BITS-1:0] sample_s2;
	logic [IDX_W-1:0]       idx_s2;
	logic [LEN_W-1:0]       taper_s2;

	always_comb begin
		if (trace_samples_q == '0) begin
			n_c = 16'sd1;
		end else if (32'(trace_samples_q) > MAX_SAMPLES) begin
			n_c = pos_t'(MAX_SAMPLES);
		end else begin
			n_c = pos_t'({1'b0, trace_samples_q});
		end
		m_c = (pos_t'({1'b0, mute_s1}) > n_c) ? n_c : pos_t'({1'b0, mute_s1});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		n_s2      <= n_c;
		m_s2      <= m_c;
		sample_s2 <= sample_s1;
		idx_s2    <= idx_s1;
		taper_s2  <= taper_s1;
	end

	// Stage 3: decide zero, taper, indicate or pass; form the ramp numerator
	act_t             act_c;
	logic [LEN_W-1:0] bound_c, num_c;
	logic             whole_c;

	always_comb begin
		pos_t i, t, ws, we, we1, w, bc, e, st, b, q, lo, hi, bnd;
		logic in_trace;
		i        = pos_t'({1'b0, idx_s2});
		t        = pos_t'({1'b0, taper_s2});
		ws       = pos_t'({1'b0, window_start_q});
		we       = pos_t'({1'b0, window_end_q});
		we1      = we + 16'sd1;
		w        = pos_t'({1'b0, indicate_width_q});
		bc       = backward_compat_q ? 16'sd1 : 16'sd0;
		in_trace = i < n_s2;
		e      = '0;
		st     = '0;
		b      = '0;
		q      = '0;
		lo     = '0;
		hi     = '0;
		bnd    = '0;
		act_c   = ACT_PASS;
		whole_c = 1'b0;
		num_c   = '0;
		if (indicate_width_q != '0) begin
			lo  = pmax(ws, pmax(m_s2 - w, 16'sd0));
			hi  = pmin(we1, pmin(m_s2 + w, n_s2));
			bnd = front_mode_q ? lo : hi;
			if (in_trace && i >= lo && i < hi) begin
				act_c = ACT_INDICATE;
			end
		end else if (front_mode_q) begin
			e       = m_s2 - bc;
			st      = e + 16'sd1;
			whole_c = e >= n_s2 - 16'sd1;
			lo      = pmax(pmax(ws, st), 16'sd0);
			hi      = pmin(we1, pmin(st + t, n_s2));
			bnd     = lo;
			num_c   = LEN_W'(i - st + (cosine_taper_q ? 16'sd0 : 16'sd1));
			priority if (in_trace && i >= ws && i <= pmin(we, e)) begin
				act_c = ACT_ZERO;
			end else if (in_trace && i >= lo && i < hi) begin
				act_c = ACT_TAPER;
			end
		end else begin
			b       = m_s2 + bc;
			q       = pmin(b, n_s2);
			whole_c = b <= 16'sd1;
			lo      = pmax(ws, pmax(16'sd0, b - t));
			hi      = pmin(we1, q);
			bnd     = hi;
			num_c   = LEN_W'(q - i);
			priority if (in_trace && i >= pmax(ws, b) && i <= pmin(we, n_s2 - 16'sd1)) begin
				act_c = ACT_ZERO;
			end else if (in_trace && i >= lo && i < hi) begin
				act_c = ACT_TAPER;
			end
		end
		bound_c = bnd[LEN_W-1:0];
	end

	logic             v_s3;
	side_t            side_s3;
	logic [LEN_W-1:0] num_s3, taper_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3  <= '{act: act_c, sample: sample_s2, bound: bound_c, whole: whole_c};
		num_s3   <= num_c;
		taper_s3 <= taper_s2;
	end

	// Taper divider: one quotient bit per stage, rounded by adding half the divisor
	logic [DVD_W-1:0]    dvd_c;
	logic [LEN_W-1:0]    dv_rem_s [1:DIV_BITS];
	logic [LEN_W-1:0]    dv_t_s   [1:DIV_BITS];
	logic [DIV_BITS-1:0] dv_low_s [1:DIV_BITS];
	logic [DIV_BITS-1:0] dv_q_s   [1:DIV_BITS];

	assign dvd_c = (cosine_taper_q ? (DVD_W'(num_s3) << NUM_SHIFT_COS)
	                               : (DVD_W'(num_s3) << (WEIGHT_BITS - 1)))
	             + DVD_W'(taper_s3 >> 1);

	for (genvar j = 1; j <= DIV_BITS; j++) begin : g_div
		logic [LEN_W-1:0]    rem_in, t_in;
		logic [DIV_BITS-1:0] low_in, q_in;
		logic [LEN_W:0]      trial;

		if (j == 1) begin : g_first
			assign rem_in = dvd_c[DVD_W-1 -: LEN_W];
			assign low_in = dvd_c[DIV_BITS-1:0];
			assign q_in   = '0;
			assign t_in   = taper_s3;
		end else begin : g_next
			assign rem_in = dv_rem_s[j-1];
			assign low_in = dv_low_s[j-1];
			assign q_in   = dv_q_s[j-1];
			assign t_in   = dv_t_s[j-1];
		end

		assign trial = {rem_in, low_in[DIV_BITS-1]};

		always_ff @(posedge clk) begin
			if (trial >= {1'b0, t_in}) begin
				dv_rem_s[j] <= LEN_W'(trial - {1'b0, t_in});
				dv_q_s[j]   <= {q_in[DIV_BITS-2:0], 1'b1};
			end else begin
				dv_rem_s[j] <= trial[LEN_W-1:0];
				dv_q_s[j]   <= {q_in[DIV_BITS-2:0], 1'b0};
			end
			dv_low_s[j] <= low_in << 1;
			dv_t_s[j]   <= t_in;
		end
	end

	// Fold the cosine argument into the lower half
	logic [DIV_BITS-1:0] xf;
	logic                upper_c;
	logic [23:0]         y_c;
	logic [Q30_W-1:0]    cos_half;

	assign xf      = dv_q_s[DIV_BITS];
	assign upper_c = xf > DIV_BITS'(1 << 23);
	assign y_c     = upper_c ? 24'(DIV_BITS'(1 << 24) - xf) : xf[23:0];

	tmt_cos u_cos (
		.clk  (clk),
		.y    (y_c),
		.half (cos_half)
	);

	// Hold the quotient and fold flag beside the cosine pipeline
	logic [DIV_BITS-1:0] xf_s [1:COS_LAT];
	logic                up_s [1:COS_LAT];

	always_ff @(posedge clk) begin
		xf_s[1] <= xf;
		up_s[1] <= upper_c;
		for (int k = 2; k <= COS_LAT; k++) begin
			xf_s[k] <= xf_s[k-1];
			up_s[k] <= up_s[k-1];
		end
	end

	// Carry the decoded word and its valid bit down to the weight stage
	logic  vld_s  [1:SIDE_LAT];
	side_t side_s [1:SIDE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= SIDE_LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[1] <= v_s3;
			for (int k = 2; k <= SIDE_LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		side_s[1] <= side_s3;
		for (int k = 2; k <= SIDE_LAT; k++) begin
			side_s[k] <= side_s[k-1];
		end
	end

	// Weight stage: pick linear or cosine, round and cap at one
	logic [Q30_W-1:0]       q30_c;
	logic [31:0]            wsel_c;
	logic [WEIGHT_BITS-1:0] wgt_c, wgt_sw;
	logic                   v_sw, v_sm;
	side_t                  side_sw, side_sm;

	always_comb begin
		q30_c = up_s[COS_LAT] ? Q30_ONE - cos_half : cos_half;
		if (cosine_taper_q) begin
			wsel_c = (32'(q30_c) + (32'd1 << (30 - WEIGHT_BITS))) >> (31 - WEIGHT_BITS);
		end else begin
			wsel_c = 32'(xf_s[COS_LAT]);
		end
		wgt_c = (wsel_c > 32'(W_ONE)) ? W_ONE : wsel_c[WEIGHT_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sw <= 1'b0;
			v_sm <= 1'b0;
			done <= 1'b0;
		end else begin
			v_sw <= vld_s[SIDE_LAT];
			v_sm <= v_sw;
			done <= v_sm;
		end
	end

	// Multiply stage
	logic signed [PW-1:0] prod_sm, rnd_c, shr_c;
	logic signed [SAMPLE_BITS-1:0] res_c;

	always_ff @(posedge clk) begin
		wgt_sw  <= wgt_c;
		side_sw <= side_s[SIDE_LAT];
		prod_sm <= PW'(signed'(side_sw.sample)) * PW'(signed'({1'b0, wgt_sw}));
		side_sm <= side_sw;
	end

	// Round half up, saturate and select the result
	always_comb begin
		rnd_c = prod_sm + (PW'(1) << (WEIGHT_BITS - 2));
		shr_c = rnd_c >>> (WEIGHT_BITS - 1);
		unique case (side_sm.act)
			ACT_PASS:     res_c = signed'(side_sm.sample);
			ACT_ZERO:     res_c = '0;
			ACT_INDICATE: res_c = SAMPLE_BITS'(indicate_value_q);
			ACT_TAPER: begin
				priority if (shr_c > S_MAX) begin
					res_c = S_MAX[SAMPLE_BITS-1:0];
				end else if (shr_c < S_MIN) begin
					res_c = S_MIN[SAMPLE_BITS-1:0];
				end else begin
					res_c = shr_c[SAMPLE_BITS-1:0];
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		sample_out        <= res_c;
		boundary_sample   <= side_sm.bound;
		whole_trace_muted <= side_sm.whole;
	end

endmodule

FILE: src/tmt_checker.sv
// Port-level checker for the trace mute and taper unit, with its bind.
module tmt_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);
	import tmt_pkg::*;

	// Reset drops the result strobe
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !done)
		else $error("result strobe high during reset");

	// Every accepted word yields a result after the fixed latency
	a_word_out: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##PIPE_LAT done)
		else $error("accepted word produced no result");

	// No result without a word accepted at the matching cycle
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, PIPE_LAT))
		else $error("result strobe without an accepted word");

	// Busy only while reset is held
	a_busy_reset: assert property (@(posedge clk) busy |-> !arst_n)
		else $error("busy outside reset");

endmodule

bind trace_mute_taper_unit tmt_checker u_tmt_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

FILE: tb/trace_mute_taper_unit_tb.sv
// Testbench for the trace mute and taper unit: directed table, then random phases.
`timescale 1ns / 100ps

module trace_mute_taper_unit_tb;
	import tmt_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int PHASE_WORDS = 45;

	typedef struct packed {
		logic [23:0] smp;
		logic [12:0] bnd;
		logic        whole;
	} mute_word_t;

	typedef struct {
		logic [23:0] smp;
		logic [11:0] idx;
		logic [12:0] mp;
		logic [12:0] tp;
		bit          known;
		mute_word_t  want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [23:0] sample_in = '0;
	logic [11:0] sample_index = '0;
	logic [12:0] mute_point = '0;
	logic [12:0] taper_samples = '0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic done;
	logic signed [23:0] sample_out;
	logic [12:0] boundary_sample;
	logic whole_trace_muted;

	// Shadow copy of the configuration registers
	bit r_front = 1'b1, r_cos = 1'b1, r_bc = 1'b0;
	bit [11:0] r_ws = 12'd0, r_we = 12'd4095;
	bit [12:0] r_n = 13'd4096, r_iw = 13'd0;
	bit [23:0] r_iv = 24'd0;

	mute_word_t muted_q [$];
	int errors = 0;
	int stall = 0;
	bit idle_on = 1'b1;

	dir_row_t dir_tab [12] = '{
		'{24'h7FFFFF, 12'd0,    13'd0,    13'd0,    1'b1, '{24'd0,     13'd1,    1'b0}},
		'{24'h800000, 12'd5,    13'd10,   13'd4,    1'b1, '{24'd0,     13'd11,   1'b0}},
		'{24'h7FFFFF, 12'd11,   13'd10,   13'd4,    1'b0, '{24'd0,     13'd0,    1'b0}},
		'{24'h7FFFFF, 12'd14,   13'd10,   13'd4,    1'b0, '{24'd0,     13'd0,    1'b0}},
		'{24'h800000, 12'd13,   13'd10,   13'd4,    1'b0, '{24'd0,     13'd0,    1'b0}},
		'{24'd1234,   12'd20,   13'd10,   13'd4,    1'b1, '{24'd1234,  13'd11,   1'b0}},
		'{24'h123456, 12'd4095, 13'd4096, 13'd4096, 1'b1, '{24'd0,     13'd4097, 1'b1}},
		'{24'hFFFFFF, 12'd4095, 13'd8191, 13'd8191, 1'b1, '{24'd0,     13'd4097, 1'b1}},
		'{24'd777,    12'd100,  13'd50,   13'd0,    1'b1, '{24'd777,   13'd51,   1'b0}},
		'{24'h7FFFFF, 12'd4095, 13'd0,    13'd4096, 1'b0, '{24'd0,     13'd0,    1'b0}},
		'{24'h800000, 12'd2048, 13'd0,    13'd4096, 1'b0, '{24'd0,     13'd0,    1'b0}},
		'{24'd4660,   12'd4094, 13'd4095, 13'd2,    1'b1, '{24'd0,     13'd4096, 1'b1}}
	};

	trace_mute_taper_unit u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sample_in(sample_in), .sample_index(sample_index),
		.mute_point(mute_point), .taper_samples(taper_samples),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
		.done(done), .sample_out(sample_out), .boundary_sample(boundary_sample),
		.whole_trace_muted(whole_trace_muted)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Raised-cosine weight in Q30, series evaluated with truncated products
	function automatic longint unsigned cos_ramp_q30(longint unsigned num, longint unsigned t);
		longint unsigned xf, y, a, a2, p, h, hh;
		bit upper;
		xf = ((num << 24) + t / 2) / t;
		upper = xf > (64'd1 << 23);
		y = upper ? (64'd1 << 24) - xf : xf;
		a = (y * 64'd3373259426) >> 24;
		a2 = (a * a) >> 30;
		p = (64'd1 << 30) - a2 / 132;
		p = (64'd1 << 30) - ((a2 * p) >> 30) / 90;
		p = (64'd1 << 30) - ((a2 * p) >> 30) / 56;
		p = (64'd1 << 30) - ((a2 * p) >> 30) / 30;
		p = (64'd1 << 30) - ((a2 * p) >> 30) / 12;
		h = ((a2 * p) >> 30) / 2;
		hh = h / 2;
		return upper ? (64'd1 << 30) - hh : hh;
	endfunction

	// Scale a sample by the Q1.15 taper weight at ramp position num of t
	function automatic longint taper_scale(longint s, longint unsigned num, longint unsigned t);
		longint unsigned w;
		longint p, r;
		if (r_cos)
			w = (cos_ramp_q30(num, t) + (64'd1 << 14)) >> 15;
		else
			w = ((num << 15) + t / 2) / t;
		if (w > 32768)
			w = 32768;
		p = s * longint'(w) + 16384;
		r = p >>> 15;
		if (r > 8388607) r = 8388607;
		if (r < -8388608) r = -8388608;
		return r;
	endfunction

	// Mute, taper or indicate one sample under the current settings
	function automatic mute_word_t mute_sample(logic [23:0] smp, logic [11:0] idx,
			logic [12:0] mp, logic [12:0] tp);
		mute_word_t o;
		longint s, i, m, t, n, ws, we, res, bnd, lo, hi, e, st, b, q, iw;
		bit in_trace, whole;
		s = longint'(signed'(smp));
		i = idx; m = mp; t = tp; ws = r_ws; we = r_we;
		iw = r_iw;
		n = r_n;
		if (n < 1) n = 1;
		if (n > 4096) n = 4096;
		if (m > n) m = n;
		in_trace = i < n;
		res = s;
		whole = 1'b0;
		if (iw != 0) begin
			lo = ws; if (m - iw > lo) lo = m - iw; if (lo < 0) lo = 0;
			hi = we + 1; if (m + iw < hi) hi = m + iw; if (n < hi) hi = n;
			if (in_trace && i >= lo && i < hi)
				res = longint'(signed'(r_iv));
			bnd = r_front ? lo : hi;
		end else if (r_front) begin
			e = m - r_bc; st = e + 1;
			whole = e >= n - 1;
			lo = ws > st ? ws : st; if (lo < 0) lo = 0;
			hi = we + 1; if (st + t < hi) hi = st + t; if (n < hi) hi = n;
			bnd = lo;
			if (in_trace && i >= ws && i <= (we < e ? we : e))
				res = 0;
			else if (in_trace && i >= lo && i < hi)
				res = taper_scale(s, i - st + (r_cos ? 0 : 1), t);
		end else begin
			b = m + r_bc; q = b < n ? b : n;
			whole = b <= 1;
			lo = ws; if (b - t > lo) lo = b - t; if (lo < 0) lo = 0;
			hi = we + 1 < q ? we + 1 : q;
			bnd = hi;
			if (in_trace && i >= (ws > b ? ws : b) && i <= (we < n - 1 ? we : n - 1))
				res = 0;
			else if (in_trace && i >= lo && i < hi)
				res = taper_scale(s, q - i, t);
		end
		o.smp = res[23:0];
		o.bnd = bnd[12:0];
		o.whole = whole;
		return o;
	endfunction

	// Present one word; hold start high until it is taken
	task automatic send_word(logic [23:0] smp, logic [11:0] idx, logic [12:0] mp,
			logic [12:0] tp, bit known, mute_word_t want);
		while (idle_on && $urandom_range(99) < 31) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		sample_in <= smp;
		sample_index <= idx;
		mute_point <= mp;
		taper_samples <= tp;
		do @(posedge clk); while (busy);
		muted_q.push_back(known ? want : mute_sample(smp, idx, mp, tp));
	endtask

	// Stop sending and wait until every expected word has come back
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (muted_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic cfg_write(cfg_reg_t r, logic [23:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_wdata <= v;
		@(posedge clk);
		case (r)
			CFG_FRONT_MODE:      r_front = v[0];
			CFG_COSINE_TAPER:    r_cos = v[0];
			CFG_BACKWARD_COMPAT: r_bc = v[0];
			CFG_WINDOW_START:    r_ws = v[11:0];
			CFG_WINDOW_END:      r_we = v[11:0];
			CFG_TRACE_SAMPLES:   r_n = v[12:0];
			CFG_INDICATE_WIDTH:  r_iw = v[12:0];
			CFG_INDICATE_VALUE:  r_iv = v;
			default: ;
		endcase
	endtask

	task automatic set_config(bit fm, bit ct, bit bc, logic [11:0] ws, logic [11:0] we,
			logic [12:0] n, logic [12:0] iw, logic [23:0] iv);
		cfg_write(CFG_FRONT_MODE, {23'd0, fm});
		cfg_write(CFG_COSINE_TAPER, {23'd0, ct});
		cfg_write(CFG_BACKWARD_COMPAT, {23'd0, bc});
		cfg_write(CFG_WINDOW_START, {12'd0, ws});
		cfg_write(CFG_WINDOW_END, {12'd0, we});
		cfg_write(CFG_TRACE_SAMPLES, {11'd0, n});
		cfg_write(CFG_INDICATE_WIDTH, {11'd0, iw});
		cfg_write(CFG_INDICATE_VALUE, iv);
		cfg_wr_en <= 1'b0;
	endtask

	// Random words: mostly near the mute point of a valid trace, some noise
	task automatic random_words(int count);
		logic [23:0] smp;
		logic [11:0] idx;
		logic [12:0] mp, tp;
		int nn, base;
		mute_word_t none;
		none = '0;
		for (int k = 0; k < count; k++) begin
			nn = (r_n == 0) ? 1 : (r_n > 4096 ? 4096 : int'(r_n));
			case ($urandom_range(9))
				0: smp = 24'h7FFFFF;
				1: smp = 24'h800000;
				default: smp = 24'($urandom());
			endcase
			mp = ($urandom_range(9) == 0) ? 13'($urandom()) : 13'($urandom_range(0, nn));
			tp = ($urandom_range(9) == 0) ? 13'($urandom()) : 13'($urandom_range(0, 40));
			if ($urandom_range(9) < 7) begin
				base = int'(mp) + $urandom_range(0, 2 * int'(tp) + 6) - int'(tp) - 3;
				if (r_iw != 0)
					base = int'(mp) + $urandom_range(0, 2 * int'(r_iw) + 2) - int'(r_iw) - 1;
				if (base < 0) base = 0;
				if (base > 4095) base = 4095;
				idx = base[11:0];
			end else begin
				idx = 12'($urandom());
			end
			send_word(smp, idx, mp, tp, 1'b0, none);
		end
	endtask

	// Check each result word against the oldest expectation
	always @(posedge clk) begin
		mute_word_t w;
		if (arst_n && done) begin
			if (muted_q.size() == 0) begin
				$display("%0t: unexpected word: sample %h boundary %0d whole %0b", $time,
					sample_out, boundary_sample, whole_trace_muted);
				errors++;
			end else begin
				w = muted_q.pop_front();
				if (sample_out !== w.smp) begin
					$display("%0t: sample_out expected %h actual %h", $time, w.smp, sample_out);
					errors++;
				end
				if (boundary_sample !== w.bnd) begin
					$display("%0t: boundary_sample expected %0d actual %0d", $time, w.bnd,
						boundary_sample);
					errors++;
				end
				if (whole_trace_muted !== w.whole) begin
					$display("%0t: whole_trace_muted expected %0b actual %0b", $time, w.whole,
						whole_trace_muted);
					errors++;
				end
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				stall <= 0;
			else
				stall <= stall + 1;
			if (stall >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words under the reset settings
		foreach (dir_tab[k])
			send_word(dir_tab[k].smp, dir_tab[k].idx, dir_tab[k].mp, dir_tab[k].tp,
				dir_tab[k].known, dir_tab[k].want);
		drain();

		// Fixed settings: each mode, the extremes, then random settings
		set_config(1'b0, 1'b0, 1'b0, 12'd0, 12'd4095, 13'd4096, 13'd0, 24'd0);
		random_words(PHASE_WORDS);
		drain();
		set_config(1'b0, 1'b1, 1'b1, 12'd0, 12'd4095, 13'd4096, 13'd0, 24'd0);
		random_words(PHASE_WORDS);
		drain();
		set_config(1'b1, 1'b0, 1'b1, 12'd0, 12'd4095, 13'd4096, 13'd0, 24'd0);
		idle_on = 1'b0;
		random_words(PHASE_WORDS);
		idle_on = 1'b1;
		drain();
		set_config(1'b1, 1'b1, 1'b0, 12'd100, 12'd300, 13'd512, 13'd0, 24'd0);
		random_words(PHASE_WORDS);
		drain();
		set_config(1'b0, 1'b0, 1'b0, 12'd400, 12'd200, 13'd512, 13'd0, 24'd0);
		random_words(PHASE_WORDS);
		drain();
		set_config(1'b1, 1'b1, 1'b0, 12'd0, 12'd4095, 13'd0, 13'd0, 24'd0);
		random_words(PHASE_WORDS);
		drain();
		set_config(1'b0, 1'b1, 1'b0, 12'd0, 12'd4095, 13'd8191, 13'd0, 24'd0);
		random_words(PHASE_WORDS);
		drain();
		set_config(1'b1, 1'b0, 1'b0, 12'd0, 12'd4095, 13'd64, 13'd8, 24'h800000);
		random_words(PHASE_WORDS);
		drain();
		set_config(1'b0, 1'b1, 1'b1, 12'd5, 12'd60, 13'd64, 13'd4096, 24'h7FFFFF);
		random_words(PHASE_WORDS);
		drain();
		for (int ph = 0; ph < 4; ph++) begin
			set_config(1'($urandom()), 1'($urandom()), 1'($urandom()), 12'($urandom()),
				12'($urandom()),
				($urandom_range(3) == 0) ? 13'($urandom()) : 13'($urandom_range(1, 300)),
				($urandom_range(2) == 0) ? 13'($urandom_range(1, 20)) : 13'd0,
				24'($urandom()));
			random_words(PHASE_WORDS);
			drain();
		end

		// Let the pipeline settle, then report
		repeat (PIPE_LAT + 10) @(posedge clk);
		if (errors == 0 && muted_q.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

FILE: sim.f
src/tmt_pkg.sv
src/tmt_cos.sv
src/trace_mute_taper_unit.sv
src/tmt_checker.sv
tb/trace_mute_taper_unit_tb.sv
